// ===== sv/s2cf_pkg.sv =====
// ----------------------------------------------------------------------------
// s2cf_pkg: shared types and constants for the spherical to Cartesian block
// Holds CORDIC widths, the arctangent table and the pipeline stage count.
// ----------------------------------------------------------------------------
package s2cf_pkg;

  localparam int unsigned CordicStages = 16;
  localparam int unsigned AtanEntries  = 24;
  localparam int unsigned NStages = (CordicStages > AtanEntries) ? AtanEntries : CordicStages;

  localparam int unsigned AngW = 17;
  localparam int unsigned MagW = 16;
  localparam int unsigned VecW = 16;
  // residual angle, degrees Q20, magnitude below 2^27
  localparam int unsigned ZW   = 29;
  // CORDIC vector Q2.30 plus headroom
  localparam int unsigned CW   = 33;

  localparam logic signed [AngW+1:0] Deg90    = 19'sd23040;
  localparam logic signed [AngW+1:0] HalfTurn = 19'sd46080;
  localparam logic signed [AngW+1:0] FullTurn = 19'sd92160;
  localparam logic signed [CW-1:0]   CordicGain = 33'sd652032874;

  function automatic logic signed [ZW-1:0] atan_q20(input logic [4:0] idx);
    logic signed [ZW-1:0] r;
    case (idx)
      5'd0:  r = 29'sd47185920;
      5'd1:  r = 29'sd27855475;
      5'd2:  r = 29'sd14718068;
      5'd3:  r = 29'sd7471121;
      5'd4:  r = 29'sd3750058;
      5'd5:  r = 29'sd1876857;
      5'd6:  r = 29'sd938658;
      5'd7:  r = 29'sd469357;
      5'd8:  r = 29'sd234682;
      5'd9:  r = 29'sd117342;
      5'd10: r = 29'sd58671;
      5'd11: r = 29'sd29335;
      5'd12: r = 29'sd14668;
      5'd13: r = 29'sd7334;
      5'd14: r = 29'sd3667;
      5'd15: r = 29'sd1833;
      5'd16: r = 29'sd917;
      5'd17: r = 29'sd458;
      5'd18: r = 29'sd229;
      5'd19: r = 29'sd115;
      5'd20: r = 29'sd57;
      5'd21: r = 29'sd29;
      5'd22: r = 29'sd14;
      5'd23: r = 29'sd7;
      default: r = '0;
    endcase
    return r;
  endfunction

  // one CORDIC rotation pair (elevation and azimuth) with passenger data
  typedef struct packed {
    logic signed [CW-1:0] xa;
    logic signed [CW-1:0] ya;
    logic signed [ZW-1:0] za;
    logic                 fa;
    logic signed [CW-1:0] xb;
    logic signed [CW-1:0] yb;
    logic signed [ZW-1:0] zb;
    logic                 fb;
    logic signed [MagW-1:0] mag;
  } cord_t;

  // wrap and fold an angle (deg Q8, 19 bit) into [-90,90]; returns flip flag
  function automatic logic signed [AngW+1:0] fold_ang(input logic signed [AngW+1:0] a,
                                                       output logic flip);
    logic signed [AngW+1:0] w;
    w = a;
    if (w >= HalfTurn) w = w - FullTurn;
    else if (w < -HalfTurn) w = w + FullTurn;
    flip = 1'b0;
    if (w > Deg90) begin
      w = HalfTurn - w;
      flip = 1'b1;
    end else if (w < -Deg90) begin
      w = -HalfTurn - w;
      flip = 1'b1;
    end
    return w;
  endfunction

endpackage

// ===== sv/s2cf_stage.sv =====
// ----------------------------------------------------------------------------
// s2cf_stage: one registered CORDIC rotation for both angles
// Rotates the elevation and azimuth vectors by atan(2^-i) and holds on stall.
// ----------------------------------------------------------------------------
module s2cf_stage
  import s2cf_pkg::*;
#(
  parameter int unsigned Idx = 0
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  en_i,
  input  logic  vld_i,
  input  cord_t d_i,
  output logic  vld_o,
  output cord_t d_o
);

  cord_t                rot_d;
  cord_t                dat_q;
  logic                 vld_q;
  logic signed [ZW-1:0] at;

  assign at = atan_q20(5'(Idx));

  // rotate both vectors toward zero residual
  always_comb begin
    rot_d = d_i;
    if (d_i.za >= 0) begin
      rot_d.xa = d_i.xa - (d_i.ya >>> Idx);
      rot_d.ya = d_i.ya + (d_i.xa >>> Idx);
      rot_d.za = d_i.za - at;
    end else begin
      rot_d.xa = d_i.xa + (d_i.ya >>> Idx);
      rot_d.ya = d_i.ya - (d_i.xa >>> Idx);
      rot_d.za = d_i.za + at;
    end
    if (d_i.zb >= 0) begin
      rot_d.xb = d_i.xb - (d_i.yb >>> Idx);
      rot_d.yb = d_i.yb + (d_i.xb >>> Idx);
      rot_d.zb = d_i.zb - at;
    end else begin
      rot_d.xb = d_i.xb + (d_i.yb >>> Idx);
      rot_d.yb = d_i.yb - (d_i.xb >>> Idx);
      rot_d.zb = d_i.zb + at;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dat_q <= rot_d;
    end
  end

  assign vld_o = vld_q;
  assign d_o   = dat_q;

endmodule

// ===== sv/s2cf_mult.sv =====
// ----------------------------------------------------------------------------
// s2cf_mult: product and rounding back end
// Forms m*sin(a'), then the X, Y, Z products, rounds and saturates to Q8.8.
// ----------------------------------------------------------------------------
module s2cf_mult
  import s2cf_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic                   vld_i,
  input  cord_t                  d_i,
  output logic                   vld_o,
  output logic signed [VecW-1:0] x_o,
  output logic signed [VecW-1:0] y_o,
  output logic signed [VecW-1:0] z_o
);

  localparam int unsigned PW = MagW + CW;  // m * Q2.30
  localparam int unsigned TW = PW - 16;    // t in Q8.22
  localparam int unsigned QW = TW + CW;    // t * trig

  // stage 1: magnitude products and trig pass-through
  logic signed [PW-1:0] ms_q, mc_q;
  logic signed [CW-1:0] sb_q, cb_q;
  // stage 2: t and rounded Z
  logic signed [TW-1:0] t_q;
  logic signed [PW-1:0] zr_q;
  logic signed [CW-1:0] sb2_q, cb2_q;
  // stage 3: final products
  logic signed [QW-1:0] px_q, py_q;
  logic signed [PW-1:0] zr2_q;
  logic [2:0]           vld_q;

  logic signed [CW-1:0] ca;
  logic signed [CW-1:0] cb;
  logic signed [PW-1:0] t_full;
  logic signed [QW-1:0] rx, ry;
  logic signed [PW-1:0] rz;

  assign ca     = d_i.fa ? -d_i.xa : d_i.xa;
  assign cb     = d_i.fb ? -d_i.xb : d_i.xb;
  assign t_full = (ms_q + PW'(33'sd32768)) >>> 16;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[1:0], vld_i};
    end
  end

  // advance the multiply pipeline
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ms_q  <= PW'(d_i.mag) * PW'(d_i.ya);
      mc_q  <= PW'(d_i.mag) * PW'(ca);
      sb_q  <= d_i.yb;
      cb_q  <= cb;
      t_q   <= TW'(t_full);
      zr_q  <= (mc_q + (PW'(1) <<< 29)) >>> 30;
      sb2_q <= sb_q;
      cb2_q <= cb_q;
      px_q  <= QW'(t_q) * QW'(cb2_q);
      py_q  <= QW'(t_q) * QW'(sb2_q);
      zr2_q <= zr_q;
    end
  end

  function automatic logic signed [VecW-1:0] sat(input logic signed [QW-1:0] v);
    if (v > QW'(32767)) return 16'sh7fff;
    if (v < -QW'(32768)) return 16'sh8000;
    return VecW'(v);
  endfunction

  assign rx = (px_q + (QW'(1) <<< 43)) >>> 44;
  assign ry = (py_q + (QW'(1) <<< 43)) >>> 44;
  assign rz = zr2_q;

  assign x_o   = sat(rx);
  assign y_o   = sat(ry);
  assign z_o   = sat(QW'(rz));
  assign vld_o = vld_q[2];

endmodule

// ===== sv/spherical_to_cartesian_force.sv =====
// ----------------------------------------------------------------------------
// spherical_to_cartesian_force: spherical to Cartesian vector conversion
//
//  channel | dir | fields (lsb first)
//  s_axis  | in  | elevation_deg[16:0], azimuth_deg[33:17], magnitude[49:34]
//  m_axis  | out | vec_x[15:0], vec_y[31:16], vec_z[47:32]
//
// One vector per cycle while the output is taken; the path is an input register,
// the unrolled chain of CORDIC stages, 3 multiply stages and the output register.
// Reset clears only valid bits. When the output register is full and not
// taken, the whole pipeline freezes; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module spherical_to_cartesian_force
  import s2cf_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // elevation_deg, azimuth_deg, magnitude
  input  logic [55:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // vec_x, vec_y, vec_z
  output logic [47:0] m_axis_tdata
);

  logic en;
  logic signed [AngW-1:0] el, az;
  logic signed [AngW+1:0] el_r, el_f, az_f;
  logic fa, fb;
  cord_t in_d, in_q;
  logic  in_vld_q;
  cord_t  chain_d [NStages+1];
  logic   chain_v [NStages+1];
  logic        out_vld;
  logic [47:0] out_d, out_q;
  logic        out_vld_q;

  // freeze everything when the output holds an untaken transaction
  assign en            = !out_vld_q || m_axis_tready;
  assign s_axis_tready = en;

  assign el = s_axis_tdata[16:0];
  assign az = s_axis_tdata[33:17];

  // remap elevation, wrap and fold both angles
  always_comb begin
    el_r = (el < 0) ? (AngW+2)'(el) - Deg90 : Deg90 - (AngW+2)'(el);
    el_f = fold_ang(el_r, fa);
    az_f = fold_ang((AngW+2)'(az), fb);
    in_d     = '0;
    in_d.xa  = CordicGain;
    in_d.xb  = CordicGain;
    in_d.za  = ZW'(el_f) <<< 12;
    in_d.zb  = ZW'(az_f) <<< 12;
    in_d.fa  = fa;
    in_d.fb  = fb;
    in_d.mag = s_axis_tdata[49:34];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (en) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      in_q <= in_d;
    end
  end

  assign chain_d[0] = in_q;
  assign chain_v[0] = in_vld_q;

  for (genvar g = 0; g < NStages; g++) begin : g_cordic
    s2cf_stage #(.Idx(g)) u_stage (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .en_i  (en),
      .vld_i (chain_v[g]),
      .d_i   (chain_d[g]),
      .vld_o (chain_v[g+1]),
      .d_o   (chain_d[g+1])
    );
  end

  s2cf_mult u_mult (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .en_i  (en),
    .vld_i (chain_v[NStages]),
    .d_i   (chain_d[NStages]),
    .vld_o (out_vld),
    .x_o   (out_d[15:0]),
    .y_o   (out_d[31:16]),
    .z_o   (out_d[47:32])
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= out_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= out_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_q;

  // a stalled output transaction holds its data
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("output changed under stall");
  // ready follows output occupancy
  a_rdy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input blocked with empty output");
  // an idle pipeline front takes no phantom item
  a_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready && !s_axis_tvalid |=> !in_vld_q)
    else $error("phantom item entered");

endmodule

// ===== tb/spherical_to_cartesian_force_tb.sv =====
// ----------------------------------------------------------------------------
// spherical_to_cartesian_force_tb: self-checking bench for the vector converter
// Drives angle/magnitude transactions with random gaps and back-pressure,
// predicts each X/Y/Z vector with a bit-exact CORDIC model and compares
// every output transaction in order.
// ----------------------------------------------------------------------------
module spherical_to_cartesian_force_tb;
  import s2cf_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned WatchdogLimit = 20000;
  localparam int unsigned DrainCycles   = 40;
  localparam longint      QuarterTurn   = 23040;
  localparam longint      Gain          = 652032874;

  typedef struct packed {
    logic signed [VecW-1:0] vz;
    logic signed [VecW-1:0] vy;
    logic signed [VecW-1:0] vx;
  } vec_t;

  // arithmetic right shift with floor semantics
  function automatic longint floor_shr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint round_shr(longint v, int s);
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic logic signed [VecW-1:0] clamp16(longint v);
    if (v > 32767) return 16'sd32767;
    if (v < -32768) return -16'sd32768;
    return v[VecW-1:0];
  endfunction

  // sine and cosine of an angle in degrees Q8, both Q2.30
  task automatic cordic_deg(input longint ang, output longint sn, output longint cs);
    longint a, x, y, z, dx, dy;
    bit     neg_cos;
    a = (ang + 2 * QuarterTurn) % (4 * QuarterTurn);
    if (a < 0) a += 4 * QuarterTurn;
    a -= 2 * QuarterTurn;
    neg_cos = 1'b0;
    if (a > QuarterTurn) begin
      a = 2 * QuarterTurn - a;
      neg_cos = 1'b1;
    end else if (a < -QuarterTurn) begin
      a = -2 * QuarterTurn - a;
      neg_cos = 1'b1;
    end
    x = Gain;
    y = 0;
    z = a * 4096;
    for (int i = 0; i < int'(NStages); i++) begin
      dx = floor_shr(y, i);
      dy = floor_shr(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(atan_q20(i[4:0]));
      end else begin
        x += dx; y -= dy; z += longint'(atan_q20(i[4:0]));
      end
    end
    sn = y;
    cs = neg_cos ? -x : x;
  endtask

  task automatic convert_vector(input logic [55:0] d, output vec_t v);
    longint el, az, m, sa, ca, sb, cb, t;
    el = longint'($signed(d[16:0]));
    az = longint'($signed(d[33:17]));
    m  = longint'($signed(d[49:34]));
    // remap elevation to polar angle; zero counts as non-negative
    if (el < 0) el = el - QuarterTurn;
    else el = QuarterTurn - el;
    cordic_deg(el, sa, ca);
    cordic_deg(az, sb, cb);
    t = round_shr(m * sa, 16);
    v.vx = clamp16(round_shr(t * cb, 44));
    v.vy = clamp16(round_shr(t * sb, 44));
    v.vz = clamp16(round_shr(m * ca, 30));
  endtask

  class vector_scoreboard;
    vec_t pending_q[$];
    int   errors;

    function new();
      errors = 0;
    endfunction

    task note_input(logic [55:0] d);
      vec_t v;
      convert_vector(d, v);
      pending_q.push_back(v);
    endtask

    function void check_output(logic [47:0] d);
      vec_t got, want;
      got = d;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected vector %h", $time, d);
        errors++;
        return;
      end
      want = pending_q.pop_front();
      if (got.vx !== want.vx) begin
        $display("%0t: vec_x expected %0d actual %0d", $time, want.vx, got.vx);
        errors++;
      end
      if (got.vy !== want.vy) begin
        $display("%0t: vec_y expected %0d actual %0d", $time, want.vy, got.vy);
        errors++;
      end
      if (got.vz !== want.vz) begin
        $display("%0t: vec_z expected %0d actual %0d", $time, want.vz, got.vz);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  // elevation_deg[16:0], azimuth_deg[33:17], magnitude[49:34]
  logic [55:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // vec_x[15:0], vec_y[31:16], vec_z[47:32]
  logic [47:0] m_axis_tdata;

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned quiet_cycles = 0;
  bit          stim_done = 1'b0;
  vector_scoreboard vectors = new();

  spherical_to_cartesian_force dut (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // send one transaction, with a random gap before it
  task automatic send_vector(input logic [16:0] el, input logic [16:0] az,
                             input logic [15:0] mag);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tdata  <= {6'b0, mag, az, el};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  function automatic logic [16:0] rand_angle();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 70) return 17'($signed($urandom_range(92160)) - 46080);
    if (r < 80) return 17'($signed($urandom_range(8)) * 5760 - 23040);
    return 17'($urandom);
  endfunction

  // note input transactions and check output transactions
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) vectors.note_input(s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) vectors.check_output(m_axis_tdata);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (stim_done && vectors.pending_q.size() == 0)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  // receiver back-pressure
  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  initial begin
    logic [16:0] angles[10];
    angles = '{17'h00000, 17'h1FFFF, 17'd23040, -17'sd23040, 17'd46080,
               -17'sd46080, 17'h0FFFF, 17'h10000, 17'd23041, 17'd11520};
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: angle extremes, quadrant edges, magnitude extremes
    send_idle_pct = 28;
    recv_idle_pct = 48;
    foreach (angles[i]) send_vector(angles[i], angles[(i + 3) % 10], 16'h8000);
    send_vector(17'd0, 17'd0, 16'h7FFF);
    send_vector(17'h1FFFF, 17'h10000, 16'h7FFF);
    send_vector(17'd23040, 17'd23040, 16'h0000);
    send_vector(-17'sd23040, 17'd0, 16'hFFFF);
    send_vector(17'd46080, -17'sd46080, 16'h0100);
    send_vector(17'd5760, 17'd34560, 16'h8000);

    for (int i = 0; i < 1950; i++) begin
      if (i == 650) begin
        send_idle_pct = 48; recv_idle_pct = 28;
      end else if (i == 1300) begin
        send_idle_pct = 0; recv_idle_pct = 0;
      end
      send_vector(rand_angle(), rand_angle(),
                  ($urandom_range(9) == 0) ? {1'($urandom_range(1)), 15'h0}
                                            : 16'($urandom));
    end
    s_axis_tvalid <= 1'b0;
    stim_done = 1'b1;

    wait (vectors.pending_q.size() == 0);
    repeat (DrainCycles) @(posedge clk_i);
    if (vectors.errors == 0 && vectors.pending_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/s2cf_pkg.sv
sv/s2cf_stage.sv
sv/s2cf_mult.sv
sv/spherical_to_cartesian_force.sv
tb/spherical_to_cartesian_force_tb.sv
